[rtl/qdrh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qdrh_pkg
// Types, constants and the prefix code table for the quality delta/run encoder.
// ----------------------------------------------------------------------------
package qdrh_pkg;

  localparam int unsigned QUAL_W      = 8;
  localparam int unsigned CODE_W      = 23;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned TABLE_SIZE  = 111;
  localparam int unsigned DELTA_BASE  = 45;
  localparam int unsigned RUN_BASE    = 90;
  localparam int signed   DELTA_LIMIT = 45;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [QUAL_W-1:0] START_QUALITY_RST = 8'd72;

  // input command codes
  localparam logic CMD_QUALITY = 1'b0;
  localparam logic CMD_END     = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [QUAL_W-1:0] quality;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  code_length;
    logic              out_of_range;
    logic              last;
  } out_item_t;

  // one entry per accepted item that produces codes; main code always present
  typedef struct packed {
    logic             pre_vld;
    logic [IDX_W-1:0] pre_idx;
    logic [IDX_W-1:0] main_idx;
    logic             main_oor;
  } qentry_t;

  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } code_entry_t;

  localparam logic [CODE_W+LEN_W-1:0] CODE_ROM [TABLE_SIZE] = '{
    {23'd5309974, 5'd23}, {23'd5309975, 5'd23}, {23'd5309976, 5'd23},
    {23'd5309977, 5'd23}, {23'd5309978, 5'd23}, {23'd5309979, 5'd23},
    {23'd5309980, 5'd23}, {23'd5309981, 5'd23}, {23'd41480, 5'd16},
    {23'd41485, 5'd16},   {23'd20741, 5'd15},   {23'd5184, 5'd13},
    {23'd6406, 5'd13},    {23'd6407, 5'd13},    {23'd7649, 5'd13},
    {23'd3292, 5'd12},    {23'd3746, 5'd12},    {23'd1297, 5'd11},
    {23'd5325, 5'd13},    {23'd7397, 5'd13},    {23'd3202, 5'd12},
    {23'd3293, 5'd12},    {23'd3747, 5'd12},    {23'd1333, 5'd11},
    {23'd1332, 5'd11},    {23'd1600, 5'd11},    {23'd1647, 5'd11},
    {23'd653, 5'd10},     {23'd667, 5'd10},     {23'd921, 5'd10},
    {23'd953, 5'd10},     {23'd327, 5'd9},      {23'd410, 5'd9},
    {23'd469, 5'd9},      {23'd479, 5'd9},      {23'd204, 5'd8},
    {23'd235, 5'd8},      {23'd82, 5'd7},       {23'd114, 5'd7},
    {23'd47, 5'd6},       {23'd55, 5'd6},       {23'd22, 5'd5},
    {23'd7, 5'd4},        {23'd4, 5'd3},        {23'd0, 5'd3},
    {23'd48, 5'd6},       {23'd1, 5'd3},        {23'd2, 5'd3},
    {23'd6, 5'd4},        {23'd21, 5'd5},       {23'd54, 5'd6},
    {23'd46, 5'd6},       {23'd103, 5'd7},      {23'd80, 5'd7},
    {23'd232, 5'd8},      {23'd199, 5'd8},      {23'd477, 5'd9},
    {23'd461, 5'd9},      {23'd397, 5'd9},      {23'd325, 5'd9},
    {23'd937, 5'd10},     {23'd801, 5'd10},     {23'd664, 5'd10},
    {23'd1848, 5'd11},    {23'd1872, 5'd11},    {23'd1330, 5'd11},
    {23'd3825, 5'd12},    {23'd3699, 5'd12},    {23'd2663, 5'd12},
    {23'd2593, 5'd12},    {23'd7648, 5'd13},    {23'd5324, 5'd13},
    {23'd14792, 5'd14},   {23'd14793, 5'd14},   {23'd20743, 5'd15},
    {23'd82969, 5'd17},   {23'd41481, 5'd16},   {23'd165937, 5'd18},
    {23'd5309982, 5'd23}, {23'd5309983, 5'd23}, {23'd2654976, 5'd22},
    {23'd2654977, 5'd22}, {23'd2654978, 5'd22}, {23'd2654979, 5'd22},
    {23'd2654980, 5'd22}, {23'd2654981, 5'd22}, {23'd2654982, 5'd22},
    {23'd2654983, 5'd22}, {23'd2654984, 5'd22}, {23'd2654985, 5'd22},
    {23'd2654986, 5'd22},
    {23'd15, 5'd4},       {23'd26, 5'd5},       {23'd56, 5'd6},
    {23'd118, 5'd7},      {23'd98, 5'd7},       {23'd233, 5'd8},
    {23'd201, 5'd8},      {23'd167, 5'd8},      {23'd463, 5'd9},
    {23'd401, 5'd9},      {23'd396, 5'd9},      {23'd957, 5'd10},
    {23'd952, 5'd10},     {23'd925, 5'd10},     {23'd920, 5'd10},
    {23'd822, 5'd10},     {23'd649, 5'd10},     {23'd652, 5'd10},
    {23'd1913, 5'd11},    {23'd101, 5'd7}
  };

  function automatic code_entry_t code_lookup(input logic [IDX_W-1:0] idx);
    code_entry_t e;
    if (idx < IDX_W'(TABLE_SIZE)) begin
      e = code_entry_t'(CODE_ROM[idx]);
    end else begin
      e = code_entry_t'(CODE_ROM[DELTA_BASE]);
    end
    return e;
  endfunction

endpackage
`default_nettype wire

[rtl/qdrh_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qdrh_front
// Accepts items, tracks previous quality and zero run, and queues code indices.
// ----------------------------------------------------------------------------
module qdrh_front #(
  parameter int unsigned MAX_RUN = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [7:0]                cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire qdrh_pkg::in_item_t        in_data,
  input  wire logic                      q_full,
  output logic                           q_push,
  output qdrh_pkg::qentry_t              q_wdata
);
  import qdrh_pkg::*;

  localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);

  logic [QUAL_W-1:0] start_r, prev_r, prev_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt, run_inc;
  logic signed [QUAL_W:0] diff;
  logic [IDX_W-1:0]  delta_idx, run_idx;
  logic              delta_oor;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign run_inc  = run_r + RUN_W'(1);
  assign run_idx  = IDX_W'(RUN_BASE) + IDX_W'(run_r);
  assign diff     = $signed({1'b0, in_data.quality}) - $signed({1'b0, prev_r});

  always_comb begin
    if (diff > (QUAL_W+1)'(DELTA_LIMIT)) begin
      delta_idx = IDX_W'(DELTA_BASE + DELTA_LIMIT);
      delta_oor = 1'b1;
    end else if (diff < -(QUAL_W+1)'(DELTA_LIMIT)) begin
      delta_idx = IDX_W'(DELTA_BASE - DELTA_LIMIT);
      delta_oor = 1'b1;
    end else begin
      delta_idx = IDX_W'(diff + (QUAL_W+1)'(DELTA_BASE));
      delta_oor = 1'b0;
    end
  end

  always_comb begin
    prev_nxt = prev_r;
    run_nxt  = run_r;
    q_push   = 1'b0;
    q_wdata  = '{pre_vld: (run_r != '0), pre_idx: run_idx,
                 main_idx: IDX_W'(DELTA_BASE), main_oor: 1'b0};
    if (accept) begin
      if (in_data.cmd == CMD_END) begin
        // flush pending run, then end code
        q_push   = 1'b1;
        prev_nxt = start_r;
        run_nxt  = '0;
      end else if (diff == '0) begin
        if (run_inc == RUN_W'(MAX_RUN)) begin
          q_push           = 1'b1;
          q_wdata.pre_vld  = 1'b0;
          q_wdata.main_idx = IDX_W'(RUN_BASE + MAX_RUN);
          run_nxt          = '0;
        end else begin
          run_nxt = run_inc;
        end
      end else begin
        q_push           = 1'b1;
        q_wdata.main_idx = delta_idx;
        q_wdata.main_oor = delta_oor;
        prev_nxt         = in_data.quality;
        run_nxt          = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_QUALITY_RST;
      prev_r  <= START_QUALITY_RST;
      run_r   <= '0;
    end else begin
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      prev_r <= prev_nxt;
      run_r  <= run_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/qdrh_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qdrh_queue
// Small FIFO of code requests between front and back.
// ----------------------------------------------------------------------------
module qdrh_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire qdrh_pkg::qentry_t  wdata,
  input  wire logic               pop,
  output qdrh_pkg::qentry_t       rdata,
  output logic                    full,
  output logic                    empty
);
  import qdrh_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  qentry_t           mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/qdrh_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// qdrh_back
// Pops code requests, looks up prefix codes and drives the output register.
// ----------------------------------------------------------------------------
module qdrh_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire qdrh_pkg::qentry_t  q_rdata,
  input  wire logic               q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output qdrh_pkg::out_item_t     out_data
);
  import qdrh_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        phase_r, phase_nxt;   // set once the run flush code went out
  logic        load;
  code_entry_t ce;
  logic        send_pre;

  assign load     = !out_valid_r || !out_stall;
  assign send_pre = q_rdata.pre_vld && !phase_r;
  assign ce       = code_lookup(send_pre ? q_rdata.pre_idx : q_rdata.main_idx);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    phase_nxt     = phase_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_data_nxt.code        = ce.bits;
        out_data_nxt.code_length = ce.len;
        out_data_nxt.out_of_range = send_pre ? 1'b0 : q_rdata.main_oor;
        out_data_nxt.last         = !send_pre;
        if (send_pre) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          q_pop     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[rtl/quality_delta_run_huffman_encoder_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// quality_delta_run_huffman_encoder_top
// Delta / zero-run prefix-code encoder for quality character records.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data   (cmd, quality)
//  out     | output    | out_valid/out_stall| out_data  (code, length, oor, last)
//  cfg     | input     | cfg_we             | cfg_wdata (start_quality)
//
//  One item per cycle is taken while the 4-entry queue has room.
//  The back end sends one code beat per cycle while out_stall is low; items with a run flush give two beats.
//  An accepted item is written into the queue, then into the output register, before its first code beat shows.
//  Synchronous reset loads start_quality = 72 and clears run, queue and output.
//  out_stall holds the output register; the queue then fills and raises in_stall.
// ----------------------------------------------------------------------------
module quality_delta_run_huffman_encoder_top #(
  parameter int unsigned MAX_RUN = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [7:0]            cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire qdrh_pkg::in_item_t    in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output qdrh_pkg::out_item_t        out_data
);
  import qdrh_pkg::*;

  logic    q_push, q_pop, q_full, q_empty;
  qentry_t q_wdata, q_rdata;

  qdrh_front #(.MAX_RUN(MAX_RUN)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  qdrh_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  qdrh_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[bench/quality_delta_run_huffman_encoder_top_test.sv]
// ----------------------------------------------------------------------------
// quality_delta_run_huffman_encoder_top_test
// Self-checking bench for the quality delta/run prefix-code encoder. Records of
// quality characters, built from zero runs and deltas of every size, plus
// noise beats, are pushed through the block with random idling on both sides.
// Expected code beats are computed in the bench and compared field by field.
// ----------------------------------------------------------------------------
module quality_delta_run_huffman_encoder_top_test;
  import qdrh_pkg::*;

  localparam int ZERO_RUN_MAX = 20;
  localparam int ZERO_SLOT    = 45;   // delta zero, also the end-of-record code
  localparam int RUN_SLOT     = 90;   // run of n zeros sits at RUN_SLOT + n
  localparam int SAT_DELTA    = 45;

  localparam int CODE_BITS [111] = '{
    5309974, 5309975, 5309976, 5309977, 5309978, 5309979, 5309980, 5309981,
    41480, 41485, 20741, 5184, 6406, 6407, 7649, 3292, 3746, 1297, 5325, 7397,
    3202, 3293, 3747, 1333, 1332, 1600, 1647, 653, 667, 921, 953, 327, 410,
    469, 479, 204, 235, 82, 114, 47, 55, 22, 7, 4, 0, 48, 1, 2, 6, 21, 54, 46,
    103, 80, 232, 199, 477, 461, 397, 325, 937, 801, 664, 1848, 1872, 1330,
    3825, 3699, 2663, 2593, 7648, 5324, 14792, 14793, 20743, 82969, 41481,
    165937, 5309982, 5309983, 2654976, 2654977, 2654978, 2654979, 2654980,
    2654981, 2654982, 2654983, 2654984, 2654985, 2654986,
    15, 26, 56, 118, 98, 233, 201, 167, 463, 401, 396, 957, 952, 925, 920,
    822, 649, 652, 1913, 101
  };

  localparam int CODE_LENS [111] = '{
    23, 23, 23, 23, 23, 23, 23, 23, 16, 16, 15, 13, 13, 13, 13, 12, 12, 11,
    13, 13, 12, 12, 12, 11, 11, 11, 11, 10, 10, 10, 10, 9, 9, 9, 9, 8, 8, 7, 7,
    6, 6, 5, 4, 3, 3, 6, 3, 3, 4, 5, 6, 6, 7, 7, 8, 8, 9, 9, 9, 9, 10, 10, 10,
    11, 11, 11, 12, 12, 12, 12, 13, 13, 14, 14, 15, 17, 16, 18, 23, 23,
    22, 22, 22, 22, 22, 22, 22, 22, 22, 22, 22,
    4, 5, 6, 7, 7, 8, 8, 8, 9, 9, 9, 10, 10, 10, 10, 10, 10, 10, 11, 7
  };

  class code_scoreboard;
    logic [7:0] start_q;
    logic [7:0] prev_q;
    int         run_len;
    out_item_t  pending_codes[$];
    int         errors;

    function new();
      start_q = START_QUALITY_RST;
      prev_q  = START_QUALITY_RST;
      run_len = 0;
      errors  = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void push_code(int slot, logic oor);
      out_item_t c;
      c.code         = 23'(CODE_BITS[slot]);
      c.code_length  = 5'(CODE_LENS[slot]);
      c.out_of_range = oor;
      c.last         = 1'b0;
      pending_codes.push_back(c);
    endfunction

    // predict the code beats caused by one accepted input beat
    function void encode_item(in_item_t it);
      int        d;
      int        before_cnt;
      logic      oor;
      out_item_t c;
      before_cnt = pending_codes.size();
      if (it.cmd == CMD_END) begin
        if (run_len != 0) push_code(RUN_SLOT + run_len, 1'b0);
        push_code(ZERO_SLOT, 1'b0);
        prev_q  = start_q;
        run_len = 0;
      end else begin
        d = int'(it.quality) - int'(prev_q);
        if (d == 0) begin
          run_len++;
          if (run_len >= ZERO_RUN_MAX) begin
            push_code(RUN_SLOT + ZERO_RUN_MAX, 1'b0);
            run_len = 0;
          end
        end else begin
          if (run_len != 0) push_code(RUN_SLOT + run_len, 1'b0);
          run_len = 0;
          oor = 1'b0;
          if (d > SAT_DELTA) begin
            d   = SAT_DELTA;
            oor = 1'b1;
          end else if (d < -SAT_DELTA) begin
            d   = -SAT_DELTA;
            oor = 1'b1;
          end
          push_code(ZERO_SLOT + d, oor);
          prev_q = it.quality;
        end
      end
      if (pending_codes.size() > before_cnt) begin
        c = pending_codes.pop_back();
        c.last = 1'b1;
        pending_codes.push_back(c);
      end
    endfunction

    function void check_code(out_item_t got);
      out_item_t exp;
      if (pending_codes.size() == 0) begin
        report($sformatf("unexpected code beat %0h len %0d", got.code, got.code_length));
        return;
      end
      exp = pending_codes.pop_front();
      if (got.code !== exp.code)
        report($sformatf("code %0h, expected %0h", got.code, exp.code));
      if (got.code_length !== exp.code_length)
        report($sformatf("code_length %0d, expected %0d", got.code_length, exp.code_length));
      if (got.out_of_range !== exp.out_of_range)
        report($sformatf("out_of_range %0b, expected %0b", got.out_of_range, exp.out_of_range));
      if (got.last !== exp.last)
        report($sformatf("last %0b, expected %0b", got.last, exp.last));
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_valid  = 1'b0;
  in_item_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_data;

  code_scoreboard sb = new();

  bit         quiet = 1'b0;           // no idling on either side while set
  logic [7:0] gen_prev  = START_QUALITY_RST;
  logic [7:0] gen_start = START_QUALITY_RST;

  quality_delta_run_huffman_encoder_top #(.MAX_RUN(ZERO_RUN_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic bit idle_now();
    return !quiet && ($urandom_range(0, 99) < 35);
  endfunction

  always @(posedge clk) begin
    out_stall <= idle_now();
  end

  // both beat monitors in one process: inputs are noted before outputs checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.encode_item(in_data);
      if (out_valid && !out_stall) sb.check_code(out_data);
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] q);
    in_item_t it;
    it.cmd     = cmd;
    it.quality = q;
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gen_prev = (cmd == CMD_END) ? gen_start : q;
  endtask

  task automatic send_quality(input int q);
    send_item(CMD_QUALITY, 8'(q));
  endtask

  task automatic send_end();
    send_item(CMD_END, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_codes.size() != 0) @(posedge clk);
    // zero-run beats may still sit in the front's run counter without a code
    repeat (16) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.start_q = v;
    gen_start  = v;
  endtask

  function automatic int pick_run();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 50) return 19;
    if (r < 62) return 20;
    if (r < 67) return 21;
    if (r < 70) return 40;
    return $urandom_range(1, 18);
  endfunction

  // next character: a random value, or one at a chosen delta from the current one, kept in 0..255
  function automatic int step_quality();
    int r;
    int d;
    int q;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom_range(0, 255);
    d = (r < 25) ? $urandom_range(46, 80) : $urandom_range(1, 45);
    if ($urandom_range(0, 1)) d = -d;
    q = int'(gen_prev) + d;
    if (q < 0 || q > 255) q = int'(gen_prev) - d;
    return q;
  endfunction

  task automatic random_phase(input int n_items);
    int sent;
    int run;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 12) begin
        send_item(1'($urandom), 8'($urandom));
        sent++;
      end else begin
        run = pick_run();
        repeat (run) send_quality(gen_prev);
        if ($urandom_range(0, 99) < 15) send_end();
        else send_quality(step_quality());
        sent += run + 1;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset start value
    send_item(CMD_END, 8'hFF);      // empty record
    send_quality(72);
    send_quality(72);
    send_quality(117);              // flush run of two, then +45
    send_quality(72);               // -45
    send_quality(0);                // saturates low
    send_quality(255);              // saturates high
    send_quality(255);
    send_end();                     // pending run flushed before end code
    send_quality(71);
    send_quality(118);              // +47
    send_quality(72);               // -46
    send_quality(73);
    send_item(CMD_END, 8'h00);
    drain();

    write_start(8'd0);
    random_phase(500);
    drain();

    write_start(8'd255);
    quiet = 1'b1;
    random_phase(500);
    quiet = 1'b0;
    drain();

    write_start(8'($urandom));
    random_phase(500);
    drain();

    write_start(8'($urandom));
    random_phase(500);
    drain();

    if (sb.pending_codes.size() != 0)
      sb.report($sformatf("%0d code beats never arrived", sb.pending_codes.size()));
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
